FILE: rtl/core/multi_policy_ready_queue_macros.svh
// assertion macros for the ready queue checker
`ifndef MULTI_POLICY_READY_QUEUE_MACROS_SVH
`define MULTI_POLICY_READY_QUEUE_MACROS_SVH

// same-cycle implication, idle during reset
`define MPRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define MPRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mprq_pkg.sv
package mprq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] RR_QUANTUM_RESET = 16'd500;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_ROTATE,
    CMD_HEAD
  } cell_cmd_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
  } slot_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic             sorted;
    logic [CNT_W-1:0] occ;
    slot_t            fresh;
    slot_t            head;
  } cell_ctrl_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  job_id;
    logic [15:0] job_time;
  } job_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  served_id;
    logic [15:0] grant_length;
    logic        job_done;
    logic [4:0]  queue_count;
  } res_item_t;

endpackage

FILE: rtl/core/mprq_cell.sv
module mprq_cell (
  input  logic                    clk,
  input  mprq_pkg::cell_ctrl_t    ctrl,
  input  logic [mprq_pkg::CNT_W-1:0] pos,
  input  mprq_pkg::slot_t         left,
  input  mprq_pkg::slot_t         right,
  input  logic                    shift_left,
  input  logic                    shift_right,
  output logic                    shift_out,
  output mprq_pkg::slot_t         slot
);
  import mprq_pkg::*;

  logic  past_tail;
  logic  longer;
  slot_t slot_next;

  // a cell moves right if it and all stored cells past it are longer than the new job
  assign past_tail = (pos >= ctrl.occ);
  assign longer    = ctrl.sorted && (slot.remaining > ctrl.fresh.remaining);
  assign shift_out = past_tail || (longer && shift_right);

  always_comb begin
    slot_next = slot;
    unique case (ctrl.cmd)
      CMD_INSERT: begin
        if (shift_left) begin
          slot_next = left;
        end else if (shift_out) begin
          slot_next = ctrl.fresh;
        end
      end
      CMD_POP: begin
        slot_next = right;
      end
      CMD_ROTATE: begin
        if ((pos + CNT_W'(1)) == ctrl.occ) begin
          slot_next = ctrl.head;
        end else begin
          slot_next = right;
        end
      end
      CMD_HEAD: begin
        if (pos == '0) begin
          slot_next = ctrl.head;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

FILE: rtl/core/multi_policy_ready_queue.sv
// ready queue of job ids with remaining run times, four scheduling policies
//
// job channel: job_valid / job_stall carry one item (insert or dispatch).
// result channel: res_valid / res_stall return exactly one result per item.
// config channel: cfg_valid / cfg_ready, always ready; index 0 selects the
// policy, index 1 the round robin quantum. write only while the queue is idle.
//
// the queue is a row of cells, head at cell 0; every cell loads from its left
// or right neighbor, the new job or the rewritten head, so an insert
// (appended or placed by remaining time), a pop and a rotate are each a
// parallel load of all cells. one item per cycle is accepted while job_stall
// is low, and its result is registered and shown the cycle after acceptance.
//
// job_stall rises only while a result waits in the output register and the
// receiver stalls; a result taken in the same cycle frees room for the next.
// reset empties the queue, sets fifo policy and a quantum of 500, and drops
// any pending result.
module multi_policy_ready_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_stall,
  input  mprq_pkg::job_item_t job_item,
  output logic                res_valid,
  input  logic                res_stall,
  output mprq_pkg::res_item_t res_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import mprq_pkg::*;

  policy_t          policy;
  logic [15:0]      quantum;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] occ_next;
  cell_ctrl_t       ctrl;
  res_item_t        res_next;
  logic             accept;
  slot_t            head;

  slot_t slots  [QUEUE_DEPTH];
  logic  shifts [QUEUE_DEPTH];

  assign cfg_ready = 1'b1;
  assign job_stall = res_valid && res_stall;
  assign accept    = job_valid && !job_stall;
  assign head      = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POL_FIFO;
      quantum <= RR_QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY:  policy  <= policy_t'(cfg_data[1:0]);
        REG_QUANTUM: quantum <= cfg_data;
        default:     quantum <= quantum;
      endcase
    end
  end

  always_comb begin
    ctrl                = '0;
    ctrl.cmd            = CMD_HOLD;
    ctrl.occ            = occ;
    ctrl.sorted         = (policy == POL_SJF) || (policy == POL_PSJF);
    ctrl.fresh.id       = job_item.job_id;
    ctrl.fresh.remaining = job_item.job_time;
    ctrl.head           = head;
    occ_next            = occ;
    res_next            = '0;
    res_next.status     = ST_OK;
    if (job_item.op == OP_INSERT) begin
      if (occ == CNT_W'(QUEUE_DEPTH)) begin
        res_next.status = ST_FULL;
      end else begin
        ctrl.cmd = CMD_INSERT;
        occ_next = occ + CNT_W'(1);
      end
    end else if (occ == '0) begin
      res_next.status = ST_EMPTY;
    end else begin
      res_next.served_id = head.id;
      unique case (policy) inside
        POL_FIFO, POL_SJF: begin
          res_next.grant_length = head.remaining;
          res_next.job_done     = 1'b1;
          ctrl.cmd              = CMD_POP;
          occ_next              = occ - CNT_W'(1);
        end
        POL_RR: begin
          if (head.remaining > quantum) begin
            res_next.grant_length = quantum;
            ctrl.head.remaining   = head.remaining - quantum;
            ctrl.cmd              = CMD_ROTATE;
          end else begin
            res_next.grant_length = head.remaining;
            res_next.job_done     = 1'b1;
            ctrl.cmd              = CMD_POP;
            occ_next              = occ - CNT_W'(1);
          end
        end
        default: begin
          if (head.remaining == '0) begin
            res_next.job_done = 1'b1;
            ctrl.cmd          = CMD_POP;
            occ_next          = occ - CNT_W'(1);
          end else begin
            res_next.grant_length = 16'd1;
            if (head.remaining == 16'd1) begin
              res_next.job_done = 1'b1;
              ctrl.cmd          = CMD_POP;
              occ_next          = occ - CNT_W'(1);
            end else begin
              ctrl.head.remaining = head.remaining - 16'd1;
              ctrl.cmd            = CMD_HEAD;
            end
          end
        end
      endcase
    end
    res_next.queue_count = 5'(occ_next);
    if (!accept) begin
      ctrl.cmd = CMD_HOLD;
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_shift;
    logic  right_shift;

    if (k == 0) begin : g_head
      assign left_slot  = '0;
      assign left_shift = 1'b0;
    end else begin : g_body
      assign left_slot  = slots[k-1];
      assign left_shift = shifts[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign right_slot  = slots[k];
      assign right_shift = 1'b1;
    end else begin : g_inner
      assign right_slot  = slots[k+1];
      assign right_shift = shifts[k+1];
    end

    mprq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (CNT_W'(k)),
      .left       (left_slot),
      .right      (right_slot),
      .shift_left (left_shift),
      .shift_right(right_shift),
      .shift_out  (shifts[k]),
      .slot       (slots[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        occ       <= occ_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= res_next;
    end
  end

endmodule

FILE: rtl/core/mprq_checker.sv
`include "multi_policy_ready_queue_macros.svh"

module mprq_checker (
  input logic                clk,
  input logic                rst,
  input logic                job_valid,
  input logic                job_stall,
  input logic                res_valid,
  input logic                res_stall,
  input mprq_pkg::res_item_t res_item
);
  import mprq_pkg::*;

  `MPRQ_ASSERT_NEXT(a_result_follows, job_valid && !job_stall, res_valid,
    "accepted item gave no result")

  `MPRQ_ASSERT_NOW(a_error_clean, res_valid && res_item.status != ST_OK,
    res_item.served_id == '0 && res_item.grant_length == '0 && !res_item.job_done,
    "error result carries a grant")

  `MPRQ_ASSERT_NOW(a_full_count, res_valid && res_item.status == ST_FULL,
    res_item.queue_count == 5'(QUEUE_DEPTH), "full insert with queue not full")

  `MPRQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(res_item), "stalled result changed")

endmodule

bind multi_policy_ready_queue mprq_checker u_mprq_checker (.*);
